// File: hdl/mtbe_pkg.sv
// Shared types, constants and helpers for the MIDI track byte encoder.
// No dependencies; imported by mtbe_ctrl, mtbe_dp and the top level.
`timescale 1ns / 1ps

package mtbe_pkg;

    localparam logic [7:0] META_PREFIX  = 8'hFF;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [7:0] STATUS_MIN   = 8'h80;
    localparam logic       VLQ_CONT     = 1'b1;   // bit 7 of a non-final VLQ byte
    localparam logic [2:0] VLQ_TOP_GRP  = 3'd4;   // 32 bits -> five 7-bit groups

    // Source of the next output byte
    typedef enum logic [2:0] {
        SEL_VLQ,
        SEL_STATUS,
        SEL_DATA1,
        SEL_DATA2,
        SEL_ZERO,
        SEL_META,
        SEL_EOT
    } t_byte_sel;

    typedef struct packed {
        logic      load;      // latch the input beat
        logic      out_load;  // load the output register
        t_byte_sel sel;
        logic [2:0] grp;      // VLQ group, 0 = least significant
        logic      last;
        logic      eot;       // final end-of-track byte: report and clear count
    } t_dp_cmd;

    typedef struct packed {
        logic       in_end;
        logic       in_realtime;
        logic [2:0] nvlq_m1;  // VLQ bytes minus one for the offered beat
        logic [1:0] msg_len;  // message length of the latched status
    } t_dp_stat;

    function automatic logic [1:0] msg_length(input logic [7:0] st);
        logic [1:0] len;
        priority if (st < STATUS_MIN)  len = 2'd1;
        else if (st < 8'hC0)          len = 2'd3;
        else if (st < 8'hE0)          len = 2'd2;
        else if (st < 8'hF0)          len = 2'd3;
        else if (st == 8'hF1 || st == 8'hF3) len = 2'd2;
        else if (st == 8'hF2)         len = 2'd3;
        else                          len = 2'd1;
        return len;
    endfunction

endpackage

// File: hdl/midi_track_byte_encoder_top.sv
// Top level of the MIDI track byte encoder: sequencer plus datapath.
// Depends on mtbe_pkg, mtbe_ctrl and mtbe_dp.
`timescale 1ns / 1ps

// Turns timed MIDI events into the body of a standard MIDI file track, one
// byte per output beat. An event beat produces the delta time since the last
// kept event as a big-endian VLQ (1 to 5 bytes, zero if time went backwards),
// then the status byte and the data bytes its status calls for; realtime
// statuses (F8 and up) are swallowed and leave the state alone. An end beat
// produces 00 FF 2F 00, carries the total track byte count on its last byte,
// and resets tick and count so the next beat starts a new track. The output
// beat with last_byte set closes each event or end beat; track_length is zero except
// on the last end-of-track byte. Rate: one input beat is taken, then its bytes
// leave through a single output register at one byte per cycle while the
// output side does not stall. The next input beat is taken in the cycle after
// the last byte is loaded, while that byte still waits in the output register.
module midi_track_byte_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_event_tick,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_data_one,
    input  logic [6:0]  i_data_two,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_track_byte,
    output logic        o_last_byte,
    output logic [31:0] o_track_length
);
    import mtbe_pkg::*;

    t_dp_cmd  cmd;   // sequencer -> datapath
    t_dp_stat stat;  // datapath -> sequencer

    mtbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mtbe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_event_tick   (i_event_tick),
        .i_status_byte  (i_status_byte),
        .i_data_one     (i_data_one),
        .i_data_two     (i_data_two),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_track_byte   (o_track_byte),
        .o_last_byte    (o_last_byte),
        .o_track_length (o_track_length)
    );

endmodule

// File: hdl/mtbe_ctrl.sv
// Sequencer for the MIDI track byte encoder: walks VLQ, message and
// end-of-track bytes. Depends on mtbe_pkg.
`timescale 1ns / 1ps

module mtbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    input  mtbe_pkg::t_dp_stat i_stat,
    output mtbe_pkg::t_dp_cmd  o_cmd
);
    import mtbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VLQ,
        S_STAT,
        S_DATA1,
        S_DATA2,
        S_END0,
        S_END1,
        S_END2,
        S_END3
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_grp, n_grp;
    logic       r_oval;
    logic       adv;
    t_dp_cmd    cmd;

    // Output register free or draining this cycle
    assign adv = !r_oval || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_grp        = r_grp;
        cmd          = '0;
        cmd.sel      = SEL_ZERO;
        cmd.grp      = r_grp;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_stat.in_end) begin
                        cmd.load = 1'b1;
                        n_state  = S_END0;
                    end else if (!i_stat.in_realtime) begin
                        cmd.load = 1'b1;
                        n_grp    = i_stat.nvlq_m1;
                        n_state  = S_VLQ;
                    end
                end
            end
            S_VLQ: begin
                cmd.sel = SEL_VLQ;
                if (adv) begin
                    cmd.out_load = 1'b1;
                    if (r_grp == 3'd0) begin
                        n_state = S_STAT;
                    end else begin
                        n_grp = r_grp - 3'd1;
                    end
                end
            end
            S_STAT: begin
                cmd.sel  = SEL_STATUS;
                cmd.last = (i_stat.msg_len == 2'd1);
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = (i_stat.msg_len == 2'd1) ? S_IDLE : S_DATA1;
                end
            end
            S_DATA1: begin
                cmd.sel  = SEL_DATA1;
                cmd.last = (i_stat.msg_len == 2'd2);
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = (i_stat.msg_len == 2'd2) ? S_IDLE : S_DATA2;
                end
            end
            S_DATA2: begin
                cmd.sel  = SEL_DATA2;
                cmd.last = 1'b1;
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_END0: begin
                cmd.sel = SEL_ZERO;
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_END1;
                end
            end
            S_END1: begin
                cmd.sel = SEL_META;
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_END2;
                end
            end
            S_END2: begin
                cmd.sel = SEL_EOT;
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_END3;
                end
            end
            S_END3: begin
                cmd.sel  = SEL_ZERO;
                cmd.last = 1'b1;
                cmd.eot  = 1'b1;
                if (adv) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_grp   <= 3'd0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
            if (cmd.out_load) begin
                r_oval <= 1'b1;
            end else if (!i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_out_valid = r_oval;
    assign o_cmd       = cmd;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && i_out_stall) |-> !cmd.out_load)
        else $error("output beat overwritten while stalled");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !cmd.out_load)
        else $error("byte emitted while idle");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && cmd.last) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after last byte");
    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp <= VLQ_TOP_GRP))
        else $error("VLQ group index out of range");
`endif

endmodule

// File: hdl/mtbe_dp.sv
// Datapath for the MIDI track byte encoder: tick and byte-count state,
// delta and VLQ sizing, byte select and output register. Depends on mtbe_pkg.
`timescale 1ns / 1ps

module mtbe_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_kind,
    input  logic [31:0]        i_event_tick,
    input  logic [7:0]         i_status_byte,
    input  logic [6:0]         i_data_one,
    input  logic [6:0]         i_data_two,
    input  mtbe_pkg::t_dp_cmd  i_cmd,
    output mtbe_pkg::t_dp_stat o_stat,
    output logic [7:0]         o_track_byte,
    output logic               o_last_byte,
    output logic [31:0]        o_track_length
);
    import mtbe_pkg::*;

    logic [31:0] r_prev_tick;
    logic [31:0] r_count;
    logic [31:0] r_delta;
    logic [7:0]  r_status;
    logic [6:0]  r_d1, r_d2;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [31:0] r_len;

    logic [31:0] delta;
    logic [2:0]  nvlq_m1;
    logic [6:0]  grp_bits;
    logic [7:0]  n_byte;

    // Clamp to zero when time runs backwards
    assign delta = (i_event_tick >= r_prev_tick) ? (i_event_tick - r_prev_tick) : 32'd0;

    always_comb begin
        priority if (delta[31:28] != 4'd0) nvlq_m1 = 3'd4;
        else if (delta[27:21] != 7'd0)     nvlq_m1 = 3'd3;
        else if (delta[20:14] != 7'd0)     nvlq_m1 = 3'd2;
        else if (delta[13:7] != 7'd0)      nvlq_m1 = 3'd1;
        else                               nvlq_m1 = 3'd0;
    end

    assign o_stat.in_end      = i_kind;
    assign o_stat.in_realtime = (i_status_byte >= REALTIME_MIN);
    assign o_stat.nvlq_m1     = nvlq_m1;
    assign o_stat.msg_len     = msg_length(r_status);

    always_comb begin
        unique case (i_cmd.grp)
            3'd0:    grp_bits = r_delta[6:0];
            3'd1:    grp_bits = r_delta[13:7];
            3'd2:    grp_bits = r_delta[20:14];
            3'd3:    grp_bits = r_delta[27:21];
            3'd4:    grp_bits = {3'd0, r_delta[31:28]};
            default: grp_bits = 7'd0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_VLQ:    n_byte = {(i_cmd.grp != 3'd0) & VLQ_CONT, grp_bits};
            SEL_STATUS: n_byte = r_status;
            SEL_DATA1:  n_byte = {1'b0, r_d1};
            SEL_DATA2:  n_byte = {1'b0, r_d2};
            SEL_META:   n_byte = META_PREFIX;
            SEL_EOT:    n_byte = META_EOT;
            SEL_ZERO:   n_byte = 8'd0;
            default:    n_byte = 8'd0;
        endcase
    end

    // Track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tick <= 32'd0;
            r_count     <= 32'd0;
        end else begin
            if (i_cmd.load) begin
                r_prev_tick <= i_kind ? 32'd0 : i_event_tick;
            end
            if (i_cmd.out_load) begin
                r_count <= i_cmd.eot ? 32'd0 : (r_count + 32'd1);
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta  <= delta;
            r_status <= i_status_byte;
            r_d1     <= i_data_one;
            r_d2     <= i_data_two;
        end
        if (i_cmd.out_load) begin
            r_byte <= n_byte;
            r_last <= i_cmd.last;
            r_len  <= i_cmd.eot ? (r_count + 32'd1) : 32'd0;
        end
    end

    assign o_track_byte   = r_byte;
    assign o_last_byte    = r_last;
    assign o_track_length = r_len;

endmodule
